// ----- hw/rtl/csl_pkg.sv -----
package csl_pkg;

  // token kinds
  localparam logic [5:0] KEnd    = 6'd0;
  localparam logic [5:0] KIdent  = 6'd13;
  localparam logic [5:0] KError  = 6'd14;
  localparam logic [5:0] KHex    = 6'd15;
  localparam logic [5:0] KFloat  = 6'd16;
  localparam logic [5:0] KInt    = 6'd17;
  localparam logic [5:0] KComma  = 6'd18;
  localparam logic [5:0] KSemi   = 6'd19;
  localparam logic [5:0] KColon  = 6'd20;
  localparam logic [5:0] KLParen = 6'd21;
  localparam logic [5:0] KRParen = 6'd22;
  localparam logic [5:0] KLBrace = 6'd23;
  localparam logic [5:0] KRBrace = 6'd24;
  localparam logic [5:0] KLBrack = 6'd25;
  localparam logic [5:0] KRBrack = 6'd26;
  localparam logic [5:0] KPlus   = 6'd27;
  localparam logic [5:0] KMinus  = 6'd28;
  localparam logic [5:0] KStar   = 6'd29;
  localparam logic [5:0] KDiv    = 6'd30;
  localparam logic [5:0] KMod    = 6'd31;
  localparam logic [5:0] KNeq    = 6'd32;
  localparam logic [5:0] KNot    = 6'd33;
  localparam logic [5:0] KEq     = 6'd34;
  localparam logic [5:0] KAssign = 6'd35;
  localparam logic [5:0] KLe     = 6'd36;
  localparam logic [5:0] KLt     = 6'd37;
  localparam logic [5:0] KGe     = 6'd38;
  localparam logic [5:0] KGt     = 6'd39;
  localparam logic [5:0] KAnd    = 6'd40;
  localparam logic [5:0] KOr     = 6'd41;

  localparam int unsigned NumKw = 12;
  localparam int unsigned KwMaxLen = 7;
  // last offset that still accepts a nonzero byte is TextBytes-2
  localparam logic [16:0] TextBytes = 17'd65536;

  // scanner modes, one-hot
  typedef enum logic [15:0] {
    MIdle    = 16'h0001,
    MIdent   = 16'h0002,
    MDot     = 16'h0004,
    MZero    = 16'h0008,
    MDec     = 16'h0010,
    MFrac    = 16'h0020,
    MHexPre  = 16'h0040,
    MHex     = 16'h0080,
    MSlash   = 16'h0100,
    MComment = 16'h0200,
    MBang    = 16'h0400,
    MEq      = 16'h0800,
    MLt      = 16'h1000,
    MGt      = 16'h2000,
    MAmp     = 16'h4000,
    MPipe    = 16'h8000
  } mode_e;

  // one result item
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [7:0]  len;
    logic [15:0] line;
    logic [15:0] col;
  } tok_t;

  // keyword byte at a position, 0 past its end
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [7:0] s [0:6];
    s = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    unique case (k)
      4'd0: s = '{"m", "a", "i", "n", 8'd0, 8'd0, 8'd0};
      4'd1: s = '{"i", "n", "t", 8'd0, 8'd0, 8'd0, 8'd0};
      4'd2: s = '{"s", "h", "o", "r", "t", 8'd0, 8'd0};
      4'd3: s = '{"l", "o", "n", "g", 8'd0, 8'd0, 8'd0};
      4'd4: s = '{"f", "l", "o", "a", "t", 8'd0, 8'd0};
      4'd5: s = '{"b", "o", "o", "l", 8'd0, 8'd0, 8'd0};
      4'd6: s = '{"s", "w", "i", "t", "c", "h", 8'd0};
      4'd7: s = '{"c", "a", "s", "e", 8'd0, 8'd0, 8'd0};
      4'd8: s = '{"b", "r", "e", "a", "k", 8'd0, 8'd0};
      4'd9: s = '{"d", "e", "f", "a", "u", "l", "t"};
      4'd10: s = '{"t", "r", "u", "e", 8'd0, 8'd0, 8'd0};
      4'd11: s = '{"f", "a", "l", "s", "e", 8'd0, 8'd0};
      default: s = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    endcase
    return s[p];
  endfunction

  function automatic logic [7:0] kw_len(input logic [3:0] k);
    unique case (k)
      4'd0, 4'd3, 4'd5, 4'd7, 4'd10: return 8'd4;
      4'd1: return 8'd3;
      4'd2, 4'd4, 4'd8, 4'd11: return 8'd5;
      4'd6: return 8'd6;
      4'd9: return 8'd7;
      default: return 8'd0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/c_subset_lexer_top.sv -----
// Channel | Dir | tdata fields (low bit up)                                  | tlast
// s_axis  | in  | ch[7:0]                                                    | -
// m_axis  | out | token_kind[5:0] start_offset[21:6] length[29:22]
//               | start_line[45:30] start_column[61:46], pad to 64           | last
// One byte is taken per cycle while ready; the scanner updates in the same cycle.
// A byte can cause two tokens; they are registered into a two-entry output queue
// that drives m_axis.
// s_axis_tready is high while the queue has room for two tokens, counting a token
// that leaves in the same cycle.
// Sustained rate is one byte per cycle unless the sink stalls or two-token bytes
// arrive in a row faster than the sink drains them.
// Reset clears the scanner to idle, counters to offset 0, line 1, column 1.
module c_subset_lexer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // kind, start_offset, length, line, column
  output logic        m_axis_tlast    // last
);

  csl_pkg::mode_e mode_q, mode_d;
  logic [11:0] cand_q, cand_d;
  logic [15:0] tstart_q, tstart_d, tline_q, tline_d, tcol_q, tcol_d;
  logic [7:0]  tlen_q, tlen_d;
  logic [15:0] off_q, off_d, line_q, line_d, col_q, col_d;

  // output queue: two entries
  typedef struct packed {
    csl_pkg::tok_t tok;
    logic          lst;
  } ent_t;
  ent_t        q_mem [2];
  logic        rd_q, wr_q;
  logic [1:0]  cnt_q;

  logic [7:0] c;
  logic       acc, drop;
  assign c   = s_axis_tdata;
  assign acc = s_axis_tvalid && s_axis_tready;

  logic is_dig, is_alp, is_ids, is_idc, is_xd, is_sp;
  always_comb begin
    is_dig = c >= "0" && c <= "9";
    is_alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    is_ids = is_alp || c == "_";
    is_idc = is_ids || is_dig;
    is_xd  = is_dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    is_sp  = c == " " || (c >= 8'd9 && c <= 8'd13);
  end

  // keyword filter at the current length, and kind lookup
  logic [11:0] filt, filt0;
  logic [5:0]  id_kind;
  always_comb begin
    filt = '0;
    filt0 = '0;
    id_kind = csl_pkg::KIdent;
    for (int k = 0; k < csl_pkg::NumKw; k++) begin
      filt[k] = cand_q[k] && tlen_q < csl_pkg::kw_len(4'(k)) &&
                csl_pkg::kw_char(4'(k), tlen_q[2:0]) == c;
      filt0[k] = csl_pkg::kw_char(4'(k), 3'd0) == c;
    end
    for (int k = csl_pkg::NumKw - 1; k >= 0; k--) begin
      if (cand_q[k] && csl_pkg::kw_len(4'(k)) == tlen_q) id_kind = 6'(k + 1);
    end
  end

  // scanner step
  logic          e0v, e1v;
  csl_pkg::tok_t e0, e1;
  logic [7:0]    tlen_g;
  always_comb begin
    logic       rescan, emit;
    logic [5:0] ek, bk;
    logic       bemit;
    mode_d = mode_q; cand_d = cand_q; tstart_d = tstart_q; tlen_d = tlen_q;
    tline_d = tline_q; tcol_d = tcol_q;
    off_d = off_q; line_d = line_q; col_d = col_q;
    tlen_g = (tlen_q == 8'hFF) ? tlen_q : tlen_q + 8'd1;
    rescan = 1'b0; emit = 1'b0; ek = csl_pkg::KError;
    bemit = 1'b0; bk = csl_pkg::KError;
    e0v = 1'b0; e1v = 1'b0;
    e0 = '0; e1 = '0;
    drop = c != 8'd0 && ({1'b0, off_q} + 17'd1 >= csl_pkg::TextBytes);
    if (acc && !drop) begin
      // pending token
      unique case (mode_q)
        csl_pkg::MIdent:
          if (is_idc) begin cand_d = filt; tlen_d = tlen_g; end
          else begin emit = 1'b1; ek = id_kind; rescan = 1'b1; end
        csl_pkg::MDot:
          if (is_dig) begin mode_d = csl_pkg::MFrac; tlen_d = tlen_g; end
          else begin emit = 1'b1; ek = csl_pkg::KError; rescan = 1'b1; end
        csl_pkg::MZero:
          if (c == "x" || c == "X") begin mode_d = csl_pkg::MHexPre; tlen_d = tlen_g; end
          else if (is_dig) begin mode_d = csl_pkg::MDec; tlen_d = tlen_g; end
          else if (c == ".") begin mode_d = csl_pkg::MFrac; tlen_d = tlen_g; end
          else begin emit = 1'b1; ek = csl_pkg::KInt; rescan = 1'b1; end
        csl_pkg::MDec:
          if (is_dig) tlen_d = tlen_g;
          else if (c == ".") begin mode_d = csl_pkg::MFrac; tlen_d = tlen_g; end
          else begin emit = 1'b1; ek = csl_pkg::KInt; rescan = 1'b1; end
        csl_pkg::MFrac:
          if (is_dig) tlen_d = tlen_g;
          else begin emit = 1'b1; ek = csl_pkg::KFloat; rescan = 1'b1; end
        csl_pkg::MHexPre:
          if (is_xd) begin mode_d = csl_pkg::MHex; tlen_d = tlen_g; end
          else begin emit = 1'b1; ek = csl_pkg::KError; rescan = 1'b1; end
        csl_pkg::MHex:
          if (is_xd) tlen_d = tlen_g;
          else begin emit = 1'b1; ek = csl_pkg::KHex; rescan = 1'b1; end
        csl_pkg::MSlash:
          if (c == "/") mode_d = csl_pkg::MComment;
          else begin emit = 1'b1; ek = csl_pkg::KDiv; rescan = 1'b1; end
        csl_pkg::MComment:
          if (c == 8'd0 || c == 8'h0A) begin mode_d = csl_pkg::MIdle; rescan = 1'b1; end
        csl_pkg::MBang:
          if (c == "=") begin tlen_d = tlen_g; emit = 1'b1; ek = csl_pkg::KNeq; end
          else begin emit = 1'b1; ek = csl_pkg::KNot; rescan = 1'b1; end
        csl_pkg::MEq:
          if (c == "=") begin tlen_d = tlen_g; emit = 1'b1; ek = csl_pkg::KEq; end
          else begin emit = 1'b1; ek = csl_pkg::KAssign; rescan = 1'b1; end
        csl_pkg::MLt:
          if (c == "=") begin tlen_d = tlen_g; emit = 1'b1; ek = csl_pkg::KLe; end
          else begin emit = 1'b1; ek = csl_pkg::KLt; rescan = 1'b1; end
        csl_pkg::MGt:
          if (c == "=") begin tlen_d = tlen_g; emit = 1'b1; ek = csl_pkg::KGe; end
          else begin emit = 1'b1; ek = csl_pkg::KGt; rescan = 1'b1; end
        csl_pkg::MAmp:
          if (c == "&") begin tlen_d = tlen_g; emit = 1'b1; ek = csl_pkg::KAnd; end
          else begin emit = 1'b1; ek = csl_pkg::KError; rescan = 1'b1; end
        csl_pkg::MPipe:
          if (c == "|") begin tlen_d = tlen_g; emit = 1'b1; ek = csl_pkg::KOr; end
          else begin emit = 1'b1; ek = csl_pkg::KError; rescan = 1'b1; end
        default: rescan = 1'b1;
      endcase
      if (emit) begin
        e0v = 1'b1;
        e0 = '{kind: ek, start: tstart_q, len: tlen_d, line: tline_q, col: tcol_q};
        mode_d = csl_pkg::MIdle;
      end
      // fresh token on this byte
      if (rescan && c != 8'd0 && !is_sp) begin
        tstart_d = off_q; tline_d = line_q; tcol_d = col_q; tlen_d = 8'd1;
        cand_d = '0;
        if (is_ids) begin cand_d = filt0; mode_d = csl_pkg::MIdent; end
        else begin
          unique case (c)
            "0": mode_d = csl_pkg::MZero;
            ".": mode_d = csl_pkg::MDot;
            "/": mode_d = csl_pkg::MSlash;
            "!": mode_d = csl_pkg::MBang;
            "=": mode_d = csl_pkg::MEq;
            "<": mode_d = csl_pkg::MLt;
            ">": mode_d = csl_pkg::MGt;
            "&": mode_d = csl_pkg::MAmp;
            "|": mode_d = csl_pkg::MPipe;
            ",": begin bemit = 1'b1; bk = csl_pkg::KComma; end
            ";": begin bemit = 1'b1; bk = csl_pkg::KSemi; end
            ":": begin bemit = 1'b1; bk = csl_pkg::KColon; end
            "(": begin bemit = 1'b1; bk = csl_pkg::KLParen; end
            ")": begin bemit = 1'b1; bk = csl_pkg::KRParen; end
            "{": begin bemit = 1'b1; bk = csl_pkg::KLBrace; end
            "}": begin bemit = 1'b1; bk = csl_pkg::KRBrace; end
            "[": begin bemit = 1'b1; bk = csl_pkg::KLBrack; end
            "]": begin bemit = 1'b1; bk = csl_pkg::KRBrack; end
            "+": begin bemit = 1'b1; bk = csl_pkg::KPlus; end
            "-": begin bemit = 1'b1; bk = csl_pkg::KMinus; end
            "*": begin bemit = 1'b1; bk = csl_pkg::KStar; end
            "%": begin bemit = 1'b1; bk = csl_pkg::KMod; end
            default:
              if (is_dig) mode_d = csl_pkg::MDec;
              else begin bemit = 1'b1; bk = csl_pkg::KError; end
          endcase
        end
        if (bemit) begin
          mode_d = csl_pkg::MIdle;
          e1v = 1'b1;
          e1 = '{kind: bk, start: off_q, len: 8'd1, line: line_q, col: col_q};
        end
      end
      // end of text, or counters
      if (c == 8'd0) begin
        tstart_d = off_q; tline_d = line_q; tcol_d = col_q;
        e1v = 1'b1;
        e1 = '{kind: csl_pkg::KEnd, start: off_q, len: 8'd0, line: line_q, col: col_q};
        mode_d = csl_pkg::MIdle;
        off_d = '0; line_d = 16'd1; col_d = 16'd1;
      end else begin
        if (c == 8'h0A) begin
          if (line_q != 16'hFFFF) line_d = line_q + 16'd1;
          col_d = 16'd1;
        end else if (col_q != 16'hFFFF) col_d = col_q + 16'd1;
        if (off_q != 16'hFFFF) off_d = off_q + 16'd1;
      end
    end
  end

  // queue control
  logic pop;
  logic [1:0] npush;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign npush = {1'b0, e0v} + {1'b0, e1v};
  assign s_axis_tready = cnt_q == 2'd0 || (cnt_q == 2'd1 && pop);
  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata = {2'b0, q_mem[rd_q].tok.col, q_mem[rd_q].tok.line,
                         q_mem[rd_q].tok.len, q_mem[rd_q].tok.start,
                         q_mem[rd_q].tok.kind};
  assign m_axis_tlast = q_mem[rd_q].lst;

  always_ff @(posedge clk_i) begin
    if (e0v) q_mem[wr_q] <= '{tok: e0, lst: !e1v};
    if (e1v) q_mem[e0v ? !wr_q : wr_q] <= '{tok: e1, lst: 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= csl_pkg::MIdle; cand_q <= '0;
      tstart_q <= '0; tlen_q <= '0; tline_q <= 16'd1; tcol_q <= 16'd1;
      off_q <= '0; line_q <= 16'd1; col_q <= 16'd1;
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= '0;
    end else begin
      mode_q <= mode_d; cand_q <= cand_d;
      tstart_q <= tstart_d; tlen_q <= tlen_d; tline_q <= tline_d; tcol_q <= tcol_d;
      off_q <= off_d; line_q <= line_d; col_q <= col_d;
      if (pop) rd_q <= !rd_q;
      wr_q <= wr_q ^ npush[0];
      cnt_q <= cnt_q + npush - {1'b0, pop};
    end
  end

  // checks
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni) line_q != 16'd0)
    else $error("line zero");
  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni) col_q != 16'd0)
    else $error("column zero");
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && c == 8'd0 |=> off_q == 16'd0 && mode_q == csl_pkg::MIdle)
    else $error("end of text did not restart");

endmodule
